@@ src/tkq_pkg.sv @@
// Shared types and constants for the touch key hold qualifier.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing else.
package tkq_pkg;

   // Fixed field widths.
   localparam int CH_W       = 4;
   localparam int TICK_IN_W  = 32;
   localparam int HOLD_W     = 32;
   localparam int THR_W      = 16;
   localparam int PERIOD_W   = 10;
   localparam int STATUS_W   = 16;
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // A set top bit in the high status byte marks the whole byte as noise.
   localparam int NOISE_BIT = 7;

   // No more than this many events are reported for one poll.
   localparam int MAX_EVENTS = 8;
   localparam int CNT_W      = 4;

   // Defaults for the top-level parameters.
   localparam int FIRST_CHANNEL_DEF = 2;
   localparam int LAST_CHANNEL_DEF  = 9;
   localparam int TICK_BITS_DEF     = 32;

   // Register values after reset.
   localparam logic [THR_W-1:0]    THR_RST     = 16'd150;
   localparam logic [PERIOD_W-1:0] PERIOD_RST  = 10'd1;
   localparam logic [CH_W-1:0]     PLAY_CH_RST = 4'd5;
   localparam logic                PLAY_EN_RST = 1'b1;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HOLD_THRESHOLD = 4'd0,
      REG_TICK_PERIOD    = 4'd1,
      REG_PLAY_CHANNEL   = 4'd2,
      REG_PLAY_ENABLE    = 4'd3
   } csr_index_type;

   // Event codes on the result channel.
   typedef enum logic [1:0] {
      EVT_PRESS   = 2'd0,
      EVT_RELEASE = 2'd1,
      EVT_DISCARD = 2'd2
   } event_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            start;  // capture a polled status word
      logic            scan;   // evaluate one channel
      logic            phase;  // 0: edge pass, 1: qualification pass
      logic [CH_W-1:0] idx;    // channel offset from the first channel
      logic            load;   // move the candidate event into the pending slot
      logic            flush;  // send the pending event as the last one of the poll
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic event_found;  // the channel under scan reports an event
      logic pend_valid;   // an event waits in the pending slot
      logic out_free;     // the output register can take a beat this cycle
   } sts_type;

endpackage

@@ src/tkq_req_if.sv @@
// Input channel of the touch key hold qualifier: one status poll per beat.
// Depends on tkq_pkg.
interface tkq_req_if;
   logic                          valid;
   logic                          ready;
   logic                          read_ok;
   logic [tkq_pkg::BYTE_W-1:0]    status_low;
   logic [tkq_pkg::BYTE_W-1:0]    status_high;
   logic [tkq_pkg::TICK_IN_W-1:0] tick_now;

   modport source (output valid, read_ok, status_low, status_high, tick_now, input ready);
   modport sink   (input valid, read_ok, status_low, status_high, tick_now, output ready);
endinterface

@@ src/tkq_rsp_if.sv @@
// Result channel of the touch key hold qualifier: one key event per beat.
// Depends on tkq_pkg.
interface tkq_rsp_if;
   logic                        valid;
   logic                        ready;
   tkq_pkg::event_kind_type     event_kind;
   logic [tkq_pkg::CH_W-1:0]    channel;
   logic [tkq_pkg::HOLD_W-1:0]  hold_ms;
   logic                        play_request;
   logic                        last_event;

   modport source (output valid, event_kind, channel, hold_ms, play_request, last_event,
                   input ready);
   modport sink   (input valid, event_kind, channel, hold_ms, play_request, last_event,
                   output ready);
endinterface

@@ src/tkq_csr_if.sv @@
// Configuration write channel of the touch key hold qualifier.
// Depends on tkq_pkg.
interface tkq_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tkq_pkg::CSR_IDX_W-1:0]    index;
   logic [tkq_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ src/tkq_ctrl.sv @@
// Controller of the touch key hold qualifier: sequences the channel scan of one poll.
// Depends on tkq_pkg; drives the datapath through tkq_pkg::cmd_type.
module tkq_ctrl #(
   parameter int FIRST_CHANNEL = tkq_pkg::FIRST_CHANNEL_DEF,
   parameter int LAST_CHANNEL  = tkq_pkg::LAST_CHANNEL_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_read_ok,
   output logic             req_ready,
   input  tkq_pkg::sts_type sts,
   output tkq_pkg::cmd_type cmd
);

   localparam int NUM_CH = LAST_CHANNEL - FIRST_CHANNEL + 1;
   localparam logic [tkq_pkg::CH_W-1:0] LAST_IDX = tkq_pkg::CH_W'(NUM_CH - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_MUL   = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic                      phase_ff, phase_in;
   logic [tkq_pkg::CH_W-1:0]  idx_ff, idx_in;
   logic                      done_ff, done_in;
   logic                      last_step;

   assign last_step = phase_ff && (idx_ff == LAST_IDX);

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      done_in   = done_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.phase = phase_ff;
      cmd.idx   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_read_ok) begin
               cmd.start = 1'b1;
               idx_in    = '0;
               phase_in  = 1'b0;
               done_in   = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            done_in  = last_step;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               phase_in = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
            if (sts.event_found) begin
               state_in = ST_MUL;
            end else if (last_step) begin
               state_in = ST_FLUSH;
            end
         end
         ST_MUL: begin
            // The pending event may only move on when the output register is free.
            if (!sts.pend_valid || sts.out_free) begin
               cmd.load = 1'b1;
               state_in = done_ff ? ST_FLUSH : ST_SCAN;
            end
         end
         ST_FLUSH: begin
            if (!sts.pend_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
         idx_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         done_ff  <= done_in;
      end
   end

endmodule

@@ src/tkq_dp.sv @@
// Datapath of the touch key hold qualifier: registers, channel state, hold time
// multiplier and the result register. Depends on tkq_pkg; controlled by tkq_ctrl.
module tkq_dp #(
   parameter int FIRST_CHANNEL = tkq_pkg::FIRST_CHANNEL_DEF,
   parameter int LAST_CHANNEL  = tkq_pkg::LAST_CHANNEL_DEF,
   parameter int TICK_BITS     = tkq_pkg::TICK_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Polled item fields.
   input  logic [tkq_pkg::BYTE_W-1:0]        req_status_low,
   input  logic [tkq_pkg::BYTE_W-1:0]        req_status_high,
   input  logic [tkq_pkg::TICK_IN_W-1:0]     req_tick_now,
   // Configuration writes.
   input  logic                              csr_valid,
   input  logic [tkq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tkq_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                              csr_ready,
   // Result beats.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tkq_pkg::event_kind_type           rsp_event_kind,
   output logic [tkq_pkg::CH_W-1:0]          rsp_channel,
   output logic [tkq_pkg::HOLD_W-1:0]        rsp_hold_ms,
   output logic                              rsp_play_request,
   output logic                              rsp_last_event,
   // Controller link.
   input  tkq_pkg::cmd_type                  cmd,
   output tkq_pkg::sts_type                  sts
);

   localparam int NUM_CH = LAST_CHANNEL - FIRST_CHANNEL + 1;
   localparam int IDX_W  = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
   localparam int PROD_W = tkq_pkg::HOLD_W + tkq_pkg::PERIOD_W;

   // Configuration registers.
   logic [tkq_pkg::THR_W-1:0]    thr_ff;
   logic [tkq_pkg::PERIOD_W-1:0] period_ff;
   logic [tkq_pkg::CH_W-1:0]     play_ch_ff;
   logic                         play_en_ff;

   // Poll state.
   logic [tkq_pkg::STATUS_W-1:0] prev_ff;
   logic [tkq_pkg::STATUS_W-1:0] status_ff;
   logic [tkq_pkg::STATUS_W-1:0] changed_ff;
   logic [tkq_pkg::STATUS_W-1:0] status_in;
   logic [TICK_BITS-1:0]         now_ff;
   logic [TICK_BITS-1:0]         press_time_ff [NUM_CH];
   logic [NUM_CH-1:0]            valid_ff;
   logic [tkq_pkg::CNT_W-1:0]    cnt_ff;

   // Candidate event from the scan step.
   tkq_pkg::event_kind_type      cand_kind_ff;
   logic [tkq_pkg::CH_W-1:0]     cand_ch_ff;
   logic [tkq_pkg::HOLD_W-1:0]   cand_diff_ff;
   logic                         cand_play_ff;

   // Pending event, held until it is known whether another one follows.
   logic                         pend_valid_ff;
   tkq_pkg::event_kind_type      pend_kind_ff;
   logic [tkq_pkg::CH_W-1:0]     pend_ch_ff;
   logic [tkq_pkg::HOLD_W-1:0]   pend_hold_ff;
   logic                         pend_play_ff;

   // Output register.
   logic                         out_valid_ff, out_valid_in;
   tkq_pkg::event_kind_type      out_kind_ff;
   logic [tkq_pkg::CH_W-1:0]     out_ch_ff;
   logic [tkq_pkg::HOLD_W-1:0]   out_hold_ff;
   logic                         out_play_ff;
   logic                         out_last_ff;

   // Scan signals.
   logic [IDX_W-1:0]             sel;
   logic [tkq_pkg::CH_W-1:0]     ch_num;
   logic                         st_bit;
   logic                         chg_bit;
   logic [TICK_BITS-1:0]         diff;
   logic                         qualify;
   logic                         evt;
   logic                         found;
   tkq_pkg::event_kind_type      evt_kind;
   logic                         evt_play;
   logic [PROD_W-1:0]            prod;
   logic                         out_free;
   logic                         load_out;

   // The high byte is dropped as noise when its top bit is set.
   assign status_in = {req_status_high[tkq_pkg::NOISE_BIT] ? '0 : req_status_high,
                       req_status_low};

   // Evaluate the channel under scan.
   always_comb begin
      sel      = cmd.idx[IDX_W-1:0];
      ch_num   = tkq_pkg::CH_W'(FIRST_CHANNEL) + cmd.idx;
      st_bit   = status_ff[ch_num];
      chg_bit  = changed_ff[ch_num];
      diff     = now_ff - press_time_ff[sel];
      qualify  = diff >= TICK_BITS'(thr_ff);
      if (cmd.phase) begin
         evt      = st_bit && !valid_ff[sel] && qualify;
         evt_kind = tkq_pkg::EVT_PRESS;
      end else begin
         evt      = chg_bit && !st_bit;
         evt_kind = valid_ff[sel] ? tkq_pkg::EVT_RELEASE : tkq_pkg::EVT_DISCARD;
      end
      evt_play = cmd.phase && (ch_num == play_ch_ff) && play_en_ff;
      found    = cmd.scan && evt && (cnt_ff < tkq_pkg::CNT_W'(tkq_pkg::MAX_EVENTS));
   end

   // Hold time in milliseconds, low bits of the product.
   assign prod = PROD_W'(cand_diff_ff) * PROD_W'(period_ff);

   assign out_free     = !out_valid_ff || rsp_ready;
   assign load_out     = (cmd.load && pend_valid_ff) || cmd.flush;
   assign out_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   assign sts.event_found = found;
   assign sts.pend_valid  = pend_valid_ff;
   assign sts.out_free    = out_free;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= tkq_pkg::THR_RST;
         period_ff  <= tkq_pkg::PERIOD_RST;
         play_ch_ff <= tkq_pkg::PLAY_CH_RST;
         play_en_ff <= tkq_pkg::PLAY_EN_RST;
      end else if (csr_valid) begin
         unique case (tkq_pkg::csr_index_type'(csr_index))
            tkq_pkg::REG_HOLD_THRESHOLD: thr_ff     <= csr_data[tkq_pkg::THR_W-1:0];
            tkq_pkg::REG_TICK_PERIOD:    period_ff  <= csr_data[tkq_pkg::PERIOD_W-1:0];
            tkq_pkg::REG_PLAY_CHANNEL:   play_ch_ff <= csr_data[tkq_pkg::CH_W-1:0];
            tkq_pkg::REG_PLAY_ENABLE:    play_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Status history, per-channel timestamps and valid flags, event count.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         valid_ff <= '0;
         cnt_ff   <= '0;
         for (int i = 0; i < NUM_CH; i++) begin
            press_time_ff[i] <= '0;
         end
      end else begin
         if (cmd.start) begin
            prev_ff <= status_in;
            cnt_ff  <= '0;
         end else if (found) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.scan) begin
            if (!cmd.phase && chg_bit) begin
               valid_ff[sel] <= 1'b0;
               if (st_bit) begin
                  press_time_ff[sel] <= now_ff;
               end
            end else if (cmd.phase && st_bit && !valid_ff[sel] && qualify) begin
               valid_ff[sel] <= 1'b1;
            end
         end
      end
   end

   // Captured poll and candidate event.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         status_ff  <= status_in;
         changed_ff <= status_in ^ prev_ff;
         now_ff     <= TICK_BITS'(req_tick_now);
      end
      if (found) begin
         cand_kind_ff <= evt_kind;
         cand_ch_ff   <= ch_num;
         cand_diff_ff <= cmd.phase ? '0 : tkq_pkg::HOLD_W'(diff);
         cand_play_ff <= evt_play;
      end
   end

   // Pending slot and output register valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Pending and output payloads.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pend_kind_ff <= cand_kind_ff;
         pend_ch_ff   <= cand_ch_ff;
         pend_hold_ff <= prod[tkq_pkg::HOLD_W-1:0];
         pend_play_ff <= cand_play_ff;
      end
      if (load_out) begin
         out_kind_ff <= pend_kind_ff;
         out_ch_ff   <= pend_ch_ff;
         out_hold_ff <= pend_hold_ff;
         out_play_ff <= pend_play_ff;
         out_last_ff <= cmd.flush;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_kind   = out_kind_ff;
   assign rsp_channel      = out_ch_ff;
   assign rsp_hold_ms      = out_hold_ff;
   assign rsp_play_request = out_play_ff;
   assign rsp_last_event   = out_last_ff;

endmodule

@@ src/touch_key_hold_qualifier.sv @@
// Touch key hold qualifier top level: joins tkq_ctrl and tkq_dp; depends on tkq_pkg and
// the channel interfaces. One status poll in, zero to eight key events out.
// Steps per poll: take the poll, scan channels 2 to 9 in two passes with a hold time
// multiply step after each event found, then close the poll.
// A failed read is taken and dropped; output stalls hold the scan once both result slots are full.
// Reset restores the register defaults and clears status history, timestamps and flags.
module touch_key_hold_qualifier #(
   parameter int FIRST_CHANNEL = tkq_pkg::FIRST_CHANNEL_DEF,
   parameter int LAST_CHANNEL  = tkq_pkg::LAST_CHANNEL_DEF,
   parameter int TICK_BITS     = tkq_pkg::TICK_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   tkq_req_if.sink      req_ch,
   tkq_rsp_if.source    rsp_ch,
   tkq_csr_if.sink      csr_ch
);

   tkq_pkg::cmd_type cmd;
   tkq_pkg::sts_type sts;

   // Scan sequencer.
   tkq_ctrl #(
      .FIRST_CHANNEL (FIRST_CHANNEL),
      .LAST_CHANNEL  (LAST_CHANNEL)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_read_ok (req_ch.read_ok),
      .req_ready   (req_ch.ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   // Channel state, arithmetic and result register.
   tkq_dp #(
      .FIRST_CHANNEL (FIRST_CHANNEL),
      .LAST_CHANNEL  (LAST_CHANNEL),
      .TICK_BITS     (TICK_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_status_low   (req_ch.status_low),
      .req_status_high  (req_ch.status_high),
      .req_tick_now     (req_ch.tick_now),
      .csr_valid        (csr_ch.valid),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .csr_ready        (csr_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_event_kind   (rsp_ch.event_kind),
      .rsp_channel      (rsp_ch.channel),
      .rsp_hold_ms      (rsp_ch.hold_ms),
      .rsp_play_request (rsp_ch.play_request),
      .rsp_last_event   (rsp_ch.last_event),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule
